// File: rtl/pspi_pkg.sv
// shared types, constants and helpers of the path segment pose interpolator
// no dependencies
package pspi_pkg;

    // segment kind codes
    localparam logic [1:0] KIND_STRAIGHT = 2'd0;
    localparam logic [1:0] KIND_LEFT     = 2'd1;
    localparam logic [1:0] KIND_RIGHT    = 2'd2;

    // register indexes
    localparam logic REG_TURNING_RADIUS = 1'b0;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;

    // angle constants, radians in Q.30
    localparam logic [47:0]        TWO_PI_Q30  = 48'd6746518852;
    localparam logic signed [34:0] TWO_PI_S35  = 35'sd6746518852;
    localparam logic signed [34:0] PI_S35      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_S35 = 35'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam int                 REDUCE_CELLS = 14;

    // payload that rides along the angle pipeline
    typedef struct packed {
        logic signed [31:0] seg_dist;
        logic signed [31:0] len;
        logic [1:0]         kind;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oh;
    } pspi_side_t;

    // rotation state of one angle
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               neg;
    } pspi_rot_t;

    // arctangent of 2^-i in Q.30
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -52'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/path_segment_pose_interpolator_unit.sv
// top level of the path segment pose interpolator: config register, angle
// reduction chain, cordic cell chain and output math
// depends on pspi_pkg, pspi_reduce_cell, pspi_cordic_cell, pspi_post
//
// usage
// - input words (s_ channel) carry one origin pose, a distance along the
//   segment, the segment length and its kind; each produces one pose word on
//   the m_ channel, in order
// - turning_radius is written over the apb port at byte address 0; reads
//   return it, pready is always high; the user must write it only while
//   the block is idle, and the block does not enforce this
// - stages: 14 range reduction, one fold, one cordic per step, five output
// - throughput is one word per cycle; the whole pipeline moves forward when
//   the output register is empty or being taken
// - when the receiver stalls with a word in the output register, every
//   stage holds and s_ready drops until m_ready returns
// - synchronous reset clears all valid bits and sets the radius to 1.0
module path_segment_pose_interpolator_unit import pspi_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // apb configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_seg_dist,
    input  logic signed [31:0] s_seg_length,
    input  logic [1:0]         s_seg_kind,
    input  logic signed [31:0] s_origin_x,
    input  logic signed [31:0] s_origin_y,
    input  logic signed [31:0] s_origin_heading,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pose_x,
    output logic signed [31:0] m_pose_y,
    output logic signed [31:0] m_pose_heading,
    output logic               m_drive_forward
);

    logic [30:0] radius_reg;
    logic        adv;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_TURNING_RADIUS)) begin
            radius_reg <= pwdata[30:0];
        end
    end

    assign prdata = (paddr[2] == REG_TURNING_RADIUS) ? {1'b0, radius_reg} : 32'd0;

    // pipeline advance
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // entry: angles to Q.30, offset so the reduction stays non-negative
    logic                         red_valid [0:REDUCE_CELLS];
    logic [1:0][47:0]             red_r     [0:REDUCE_CELLS];
    pspi_side_t                   red_side  [0:REDUCE_CELLS];

    localparam logic [47:0] RED_OFFSET = TWO_PI_Q30 << (REDUCE_CELLS - 1);

    always_comb begin
        red_valid[0]          = s_valid;
        red_r[0][0]           = (48'(s_origin_heading) << 14) + RED_OFFSET;
        red_r[0][1]           = (48'(s_seg_dist) << 14) + RED_OFFSET;
        red_side[0].seg_dist  = s_seg_dist;
        red_side[0].len       = s_seg_length;
        red_side[0].kind      = s_seg_kind;
        red_side[0].ox        = s_origin_x;
        red_side[0].oy        = s_origin_y;
        red_side[0].oh        = s_origin_heading;
    end

    // range reduction cells, largest multiple first
    genvar gr;
    generate
        for (gr = 0; gr < REDUCE_CELLS; gr++) begin : g_red
            pspi_reduce_cell #(
                .SHIFT(REDUCE_CELLS - 1 - gr)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .adv      (adv),
                .in_valid (red_valid[gr]),
                .in_r     (red_r[gr]),
                .in_side  (red_side[gr]),
                .out_valid(red_valid[gr+1]),
                .out_r    (red_r[gr+1]),
                .out_side (red_side[gr+1])
            );
        end
    endgenerate

    // fold into [-pi/2, pi/2] and seed the rotation
    logic                         cor_valid [0:CORDIC_STEPS];
    pspi_rot_t [1:0]              cor_rot   [0:CORDIC_STEPS];
    pspi_side_t                   cor_side  [0:CORDIC_STEPS];

    logic                         fold_valid_reg;
    pspi_rot_t [1:0]              fold_rot_reg;
    pspi_rot_t [1:0]              fold_rot_next;
    pspi_side_t                   fold_side_reg;

    always_comb begin
        logic signed [34:0] rs;
        for (int k = 0; k < 2; k++) begin
            rs = signed'({2'b00, red_r[REDUCE_CELLS][k][32:0]});
            if (rs >= PI_S35) begin
                rs = rs - TWO_PI_S35;
            end
            fold_rot_next[k].x   = GAIN_Q30;
            fold_rot_next[k].y   = 34'sd0;
            fold_rot_next[k].neg = 1'b0;
            if (rs > HALF_PI_S35) begin
                rs = rs - PI_S35;
                fold_rot_next[k].neg = 1'b1;
            end else if (rs < -HALF_PI_S35) begin
                rs = rs + PI_S35;
                fold_rot_next[k].neg = 1'b1;
            end
            fold_rot_next[k].z = rs[33:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
        end else if (adv) begin
            fold_valid_reg <= red_valid[REDUCE_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fold_rot_reg  <= fold_rot_next;
            fold_side_reg <= red_side[REDUCE_CELLS];
        end
    end

    assign cor_valid[0] = fold_valid_reg;
    assign cor_rot[0]   = fold_rot_reg;
    assign cor_side[0]  = fold_side_reg;

    // cordic cell chain
    genvar gc;
    generate
        for (gc = 0; gc < CORDIC_STEPS; gc++) begin : g_cor
            pspi_cordic_cell #(
                .STEP(gc)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .adv      (adv),
                .in_valid (cor_valid[gc]),
                .in_rot   (cor_rot[gc]),
                .in_side  (cor_side[gc]),
                .out_valid(cor_valid[gc+1]),
                .out_rot  (cor_rot[gc+1]),
                .out_side (cor_side[gc+1])
            );
        end
    endgenerate

    // offset math and output register
    pspi_post u_post (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .radius       (radius_reg),
        .in_valid     (cor_valid[CORDIC_STEPS]),
        .in_rot       (cor_rot[CORDIC_STEPS]),
        .in_side      (cor_side[CORDIC_STEPS]),
        .out_valid    (m_valid),
        .pose_x       (m_pose_x),
        .pose_y       (m_pose_y),
        .pose_heading (m_pose_heading),
        .drive_forward(m_drive_forward)
    );

endmodule

// File: rtl/pspi_reduce_cell.sv
// one range reduction cell: conditional subtract of 2*pi shifted by SHIFT
// depends on pspi_pkg
module pspi_reduce_cell import pspi_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [1:0][47:0]    in_r,
    input  pspi_side_t          in_side,
    output logic                out_valid,
    output logic [1:0][47:0]    out_r,
    output pspi_side_t          out_side
);

    localparam logic [47:0] STEP_C = TWO_PI_Q30 << SHIFT;

    logic                valid_reg;
    logic [1:0][47:0]    r_reg;
    logic [1:0][47:0]    r_next;
    pspi_side_t          side_reg;

    // restoring subtract on both angles
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            r_next[k] = (in_r[k] >= STEP_C) ? (in_r[k] - STEP_C) : in_r[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;

endmodule

// File: rtl/pspi_cordic_cell.sv
// one rotation step of the cordic chain, for heading and distance angles
// depends on pspi_pkg
module pspi_cordic_cell import pspi_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  pspi_rot_t [1:0]   in_rot,
    input  pspi_side_t        in_side,
    output logic              out_valid,
    output pspi_rot_t [1:0]   out_rot,
    output pspi_side_t        out_side
);

    localparam logic signed [33:0] ATAN_C = signed'({2'b00, atan_q30(STEP)});

    logic              valid_reg;
    pspi_rot_t [1:0]   rot_reg;
    pspi_rot_t [1:0]   rot_next;
    pspi_side_t        side_reg;

    // rotate toward zero residual angle
    always_comb begin
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        for (int k = 0; k < 2; k++) begin
            xs = in_rot[k].x >>> STEP;
            ys = in_rot[k].y >>> STEP;
            rot_next[k].neg = in_rot[k].neg;
            if (!in_rot[k].z[33]) begin
                rot_next[k].x = in_rot[k].x - ys;
                rot_next[k].y = in_rot[k].y + xs;
                rot_next[k].z = in_rot[k].z - ATAN_C;
            end else begin
                rot_next[k].x = in_rot[k].x + ys;
                rot_next[k].y = in_rot[k].y - xs;
                rot_next[k].z = in_rot[k].z + ATAN_C;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rot_reg  <= rot_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rot   = rot_reg;
    assign out_side  = side_reg;

endmodule

// File: rtl/pspi_post.sv
// offset scaling, rotation by heading and pose sum: five pipeline stages
// depends on pspi_pkg
module pspi_post import pspi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic [30:0]        radius,
    input  logic               in_valid,
    input  pspi_rot_t [1:0]    in_rot,
    input  pspi_side_t         in_side,
    output logic               out_valid,
    output logic signed [31:0] pose_x,
    output logic signed [31:0] pose_y,
    output logic signed [31:0] pose_heading,
    output logic               drive_forward
);

    // fields that only need to reach the output
    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] head;
        logic               fwd;
    } tail_t;

    // stage 1: sine and cosine, scale by radius
    logic               p1_valid_reg;
    logic signed [63:0] p1_d_reg;
    logic signed [65:0] p1_ldx_reg;
    logic signed [66:0] p1_ldy_reg;
    logic signed [33:0] p1_ch_reg, p1_sh_reg;
    logic               p1_arc_reg, p1_right_reg;
    tail_t              p1_tail_reg;

    logic signed [33:0] ch, sh, sd, cd;
    logic signed [31:0] rad_s;
    logic signed [34:0] omc;
    logic signed [32:0] hsum;
    tail_t              p1_tail_next;

    always_comb begin
        ch    = in_rot[0].neg ? -in_rot[0].x : in_rot[0].x;
        sh    = in_rot[0].neg ? -in_rot[0].y : in_rot[0].y;
        cd    = in_rot[1].neg ? -in_rot[1].x : in_rot[1].x;
        sd    = in_rot[1].neg ? -in_rot[1].y : in_rot[1].y;
        rad_s = signed'({1'b0, radius});
        omc   = 35'sh40000000 - 35'(cd);
        case (in_side.kind)
            KIND_LEFT:  hsum = 33'(in_side.oh) + 33'(in_side.seg_dist);
            KIND_RIGHT: hsum = 33'(in_side.oh) - 33'(in_side.seg_dist);
            default:    hsum = 33'(in_side.oh);
        endcase
        p1_tail_next.ox   = in_side.ox;
        p1_tail_next.oy   = in_side.oy;
        p1_tail_next.head = sat32(52'(hsum));
        p1_tail_next.fwd  = (in_side.len > 32'sd0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_d_reg     <= 64'(in_side.seg_dist) * 64'(rad_s);
            p1_ldx_reg   <= 66'(sd) * 66'(rad_s);
            p1_ldy_reg   <= 67'(omc) * 67'(rad_s);
            p1_ch_reg    <= ch;
            p1_sh_reg    <= sh;
            p1_arc_reg   <= (in_side.kind == KIND_LEFT) || (in_side.kind == KIND_RIGHT);
            p1_right_reg <= (in_side.kind == KIND_RIGHT);
            p1_tail_reg  <= p1_tail_next;
        end
    end

    // stage 2: round to Q16.16 and pick the local offset
    logic               p2_valid_reg;
    logic signed [47:0] p2_a_reg, p2_b_reg;
    logic signed [33:0] p2_ch_reg, p2_sh_reg;
    tail_t              p2_tail_reg;

    logic signed [63:0] d_full;
    logic signed [65:0] ldx_full;
    logic signed [66:0] ldy_full;
    logic signed [47:0] ldy_s;
    logic signed [47:0] a_next, b_next;

    always_comb begin
        d_full   = (p1_d_reg + 64'sd32768) >>> 16;
        ldx_full = (p1_ldx_reg + 66'sd536870912) >>> 30;
        ldy_full = (p1_ldy_reg + 67'sd536870912) >>> 30;
        ldy_s    = p1_right_reg ? -ldy_full[47:0] : ldy_full[47:0];
        a_next   = p1_arc_reg ? ldx_full[47:0] : d_full[47:0];
        b_next   = p1_arc_reg ? ldy_s : 48'sd0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_a_reg    <= a_next;
            p2_b_reg    <= b_next;
            p2_ch_reg   <= p1_ch_reg;
            p2_sh_reg   <= p1_sh_reg;
            p2_tail_reg <= p1_tail_reg;
        end
    end

    // stage 3: partial products of the rotation, order a*ch, b*sh, a*sh, b*ch
    logic                     p3_valid_reg;
    logic signed [65:0]       p3_hi_reg [0:3];
    logic signed [50:0]       p3_lo_reg [0:3];
    tail_t                    p3_tail_reg;

    logic signed [47:0]       mv [0:3];
    logic signed [33:0]       mc [0:3];

    always_comb begin
        mv[0] = p2_a_reg;  mc[0] = p2_ch_reg;
        mv[1] = p2_b_reg;  mc[1] = p2_sh_reg;
        mv[2] = p2_a_reg;  mc[2] = p2_sh_reg;
        mv[3] = p2_b_reg;  mc[3] = p2_ch_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                p3_hi_reg[j] <= 66'(signed'(mv[j][47:16])) * 66'(mc[j]);
                p3_lo_reg[j] <= 51'(signed'({1'b0, mv[j][15:0]})) * 51'(mc[j]);
            end
            p3_tail_reg <= p2_tail_reg;
        end
    end

    // stage 4: recombine and round each product back to Q16.16
    logic                     p4_valid_reg;
    logic signed [49:0]       p4_rq_reg [0:3];
    tail_t                    p4_tail_reg;

    logic signed [49:0]       rq_next [0:3];

    always_comb begin
        logic signed [50:0] part;
        logic signed [65:0] sum;
        for (int j = 0; j < 4; j++) begin
            part       = (p3_lo_reg[j] + 51'sd536870912) >>> 16;
            sum        = (p3_hi_reg[j] + 66'(part)) >>> 14;
            rq_next[j] = sum[49:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_rq_reg   <= rq_next;
            p4_tail_reg <= p3_tail_reg;
        end
    end

    // stage 5: add origin, saturate into the output register
    logic               p5_valid_reg;
    logic signed [31:0] px_reg, py_reg, ph_reg;
    logic               fwd_reg;
    logic signed [51:0] sx, sy;

    always_comb begin
        sx = 52'(p4_tail_reg.ox) + 52'(p4_rq_reg[0]) - 52'(p4_rq_reg[1]);
        sy = 52'(p4_tail_reg.oy) + 52'(p4_rq_reg[2]) + 52'(p4_rq_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg  <= sat32(sx);
            py_reg  <= sat32(sy);
            ph_reg  <= p4_tail_reg.head;
            fwd_reg <= p4_tail_reg.fwd;
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
        end
    end

    assign out_valid     = p5_valid_reg;
    assign pose_x        = px_reg;
    assign pose_y        = py_reg;
    assign pose_heading  = ph_reg;
    assign drive_forward = fwd_reg;

endmodule

// File: rtl/pspi_checker.sv
// port level checks of the path segment pose interpolator, bound to the top
// depends on path_segment_pose_interpolator_unit
module pspi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_pose_x,
    input logic [31:0] m_pose_y,
    input logic [31:0] m_pose_heading,
    input logic        m_drive_forward
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pose_x) && $stable(m_pose_y)
            && $stable(m_pose_heading) && $stable(m_drive_forward))
        else $error("stalled result word changed");

    // no result word right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

    // an empty output always takes input
    a_ready_when_empty: assert property (@(posedge aclk)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // radius register reads back 31 bits with pready held high
    a_cfg_read: assert property (@(posedge aclk)
        pready && !prdata[31])
        else $error("configuration port read or ready wrong");

endmodule

bind path_segment_pose_interpolator_unit pspi_checker u_pspi_checker (.*);

// File: verif/tb.sv
// testbench of path_segment_pose_interpolator_unit: directed table then random
// segment samples, checked field by field against a built-in pose predictor or typed-in poses
// depends on pspi_pkg and the rtl of the top level
module tb import pspi_pkg::*;;

    localparam int  STEPS       = 16;
    localparam int  LATENCY     = 20 + STEPS;
    localparam int  NUM_PHASES  = 6;
    localparam int  RAND_ITEMS  = 272;
    localparam longint PI_V     = 64'sd3373259426;
    localparam longint TWO_PI_V = 64'sd6746518852;
    localparam longint HALF_PI_V = 64'sd1686629713;
    localparam longint GAIN_V   = 64'sd652032874;
    localparam longint HALF_V   = 64'sd536870912;
    localparam longint ONE_V    = 64'sd1073741824;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] heading;
        logic               fwd;
    } pose_t;

    typedef struct {
        logic signed [31:0] seg_dist;
        logic signed [31:0] len;
        logic [1:0]         kind;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oh;
        bit                 typed;
        pose_t              want;
    } seg_t;

    logic aclk, aresetn;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic s_valid, s_ready, m_valid, m_ready, m_drive_forward;
    logic signed [31:0] s_seg_dist, s_seg_length, s_origin_x, s_origin_y, s_origin_heading;
    logic [1:0] s_seg_kind;
    logic signed [31:0] m_pose_x, m_pose_y, m_pose_heading;

    logic [30:0] radius;
    pose_t       pending_poses[$];
    int          errors = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    path_segment_pose_interpolator_unit #(.CORDIC_STEPS(STEPS)) DUT (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #3000000;
        $display("tb NOT OK");
        $finish;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d (word %0d)", what, got, want, words_out);
        errors++;
    endtask

    function automatic longint sat_q16(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // rounded product of a length and a q.30 factor, split to stay in 64 bits
    function automatic longint scale_q30(longint v, longint c);
        longint hi, lo, part;
        hi = v >>> 16;
        lo = v - hi * 65536;
        part = (lo * c + HALF_V) >>> 16;
        return (hi * c + part) >>> 14;
    endfunction

    // q.30 sine and cosine of a q16.16 angle
    function automatic void sin_cos(input longint a, output longint s, output longint c);
        longint r, x, y, z, xs, ys;
        bit flip;
        r = (a * 16384) % TWO_PI_V;
        flip = 1'b0;
        if (r < 0) r += TWO_PI_V;
        if (r >= PI_V) r -= TWO_PI_V;
        if (r > HALF_PI_V) begin
            r -= PI_V;
            flip = 1'b1;
        end else if (r < -HALF_PI_V) begin
            r += PI_V;
            flip = 1'b1;
        end
        x = GAIN_V;
        y = 0;
        z = r;
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= longint'(atan_q30(i));
            end else begin
                x += ys;
                y -= xs;
                z += longint'(atan_q30(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // pose at the given distance along one segment
    function automatic pose_t segment_pose(seg_t sg);
        pose_t p;
        longint sh, ch, sd, cd, ldx, ldy, dx, dy, head, d, rad;
        rad = longint'(radius);
        sin_cos(longint'(sg.oh), sh, ch);
        if (sg.kind == KIND_LEFT || sg.kind == KIND_RIGHT) begin
            sin_cos(longint'(sg.seg_dist), sd, cd);
            ldx = (sd * rad + HALF_V) >>> 30;
            ldy = ((ONE_V - cd) * rad + HALF_V) >>> 30;
            if (sg.kind == KIND_RIGHT) begin
                ldy = -ldy;
                head = longint'(sg.oh) - longint'(sg.seg_dist);
            end else begin
                head = longint'(sg.oh) + longint'(sg.seg_dist);
            end
            dx = scale_q30(ldx, ch) - scale_q30(ldy, sh);
            dy = scale_q30(ldx, sh) + scale_q30(ldy, ch);
        end else begin
            // straight, and the unused fourth kind
            d = (longint'(sg.seg_dist) * rad + 32768) >>> 16;
            dx = scale_q30(d, ch);
            dy = scale_q30(d, sh);
            head = longint'(sg.oh);
        end
        p.x = 32'(sat_q16(longint'(sg.ox) + dx));
        p.y = 32'(sat_q16(longint'(sg.oy) + dy));
        p.heading = 32'(sat_q16(head));
        p.fwd = (sg.len > 0);
        return p;
    endfunction

    // apb write of the radius, then read back
    task automatic write_radius(logic [31:0] val);
        paddr = {REG_TURNING_RADIUS, 2'b00};
        pwdata = val;
        pwrite = 1'b1;
        psel = 1'b1;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        radius = val[30:0];
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata[30:0] != radius) report_mismatch("radius readback", prdata[30:0], radius);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // one segment word on the input channel, starting at a falling edge
    task automatic send_segment(seg_t sg);
        pose_t p;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        p = sg.typed ? sg.want : segment_pose(sg);
        s_seg_dist = sg.seg_dist;
        s_seg_length = sg.len;
        s_seg_kind = sg.kind;
        s_origin_x = sg.ox;
        s_origin_y = sg.oy;
        s_origin_heading = sg.oh;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_poses = {pending_poses, p};
        words_in++;
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 1647100)) - 32'sd823550;
            default: return $signed($urandom_range(0, 205888)) - 32'sd102944;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_pos();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $signed($urandom_range(0, 2 ** 26)) - 32'sd33554432;
    endfunction

    function automatic seg_t rand_segment();
        seg_t sg;
        sg.seg_dist = rand_angle();
        sg.len = $urandom;
        sg.kind = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        sg.ox = rand_pos();
        sg.oy = rand_pos();
        sg.oh = rand_angle();
        sg.typed = 1'b0;
        return sg;
    endfunction

    // receiver backpressure
    always @(negedge aclk) begin
        m_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        pose_t w;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (pending_poses.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                w = pending_poses.pop_front();
                if (m_pose_x != w.x) report_mismatch("pose_x", m_pose_x, w.x);
                if (m_pose_y != w.y) report_mismatch("pose_y", m_pose_y, w.y);
                if (m_pose_heading != w.heading)
                    report_mismatch("pose_heading", m_pose_heading, w.heading);
                if (m_drive_forward != w.fwd)
                    report_mismatch("drive_forward", m_drive_forward, w.fwd);
            end
        end
    end

    // directed rows: pose typed in where the origin is passed straight through
    seg_t directed[$];

    function automatic seg_t row(logic [31:0] seg_dist, logic [31:0] len, logic [1:0] kind,
                                 logic [31:0] ox, logic [31:0] oy, logic [31:0] oh,
                                 bit typed);
        seg_t sg;
        sg.seg_dist = seg_dist;
        sg.len = len;
        sg.kind = kind;
        sg.ox = ox;
        sg.oy = oy;
        sg.oh = oh;
        sg.typed = typed;
        sg.want.x = ox;
        sg.want.y = oy;
        sg.want.heading = oh;
        sg.want.fwd = ($signed(len) > 0);
        return sg;
    endfunction

    // append one row to the directed table
    function automatic void add_row(seg_t sg);
        directed = {directed, sg};
    endfunction

    initial begin
        logic [31:0] radii[NUM_PHASES];
        radii = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF};
        radii[4] = $urandom_range(1, 32'h7FFF_FFFF);

        // zero distance straights and fourth-kind rows keep the origin
        add_row(row(0, 0, KIND_STRAIGHT, 0, 0, 0, 1));
        add_row(row(0, 1, KIND_STRAIGHT, 32'h7FFFFFFF, 32'h80000000, 32'h12345, 1));
        add_row(row(0, 32'h80000000, KIND_STRAIGHT, 32'h80000000,
                    32'h7FFFFFFF, 32'h80000000, 1));
        add_row(row(0, 32'h7FFFFFFF, 2'd3, 32'hFFFFFFFF, 1, 32'h7FFFFFFF, 1));
        add_row(row(0, 32'hFFFFFFFF, 2'd3, 5, 32'hFFFFFFFF, 0, 1));
        // every kind, extremes, overflow of heading and position
        add_row(row(32'h10000, 1, KIND_STRAIGHT, 0, 0, 0, 0));
        add_row(row(32'h19220, 1, KIND_LEFT, 0, 0, 0, 0));
        add_row(row(32'h19220, 1, KIND_RIGHT, 0, 0, 32'h3243F, 0));
        add_row(row(32'h7FFFFFFF, 1, KIND_LEFT, 0, 0, 32'h7FFFFFFF, 0));
        add_row(row(32'h7FFFFFFF, 1, KIND_RIGHT, 0, 0, 32'h80000000, 0));
        add_row(row(32'h80000000, 1, KIND_LEFT, 0, 0, 32'h80000000, 0));
        add_row(row(32'h80000000, 1, KIND_RIGHT, 0, 0, 32'h7FFFFFFF, 0));
        add_row(row(32'h7FFFFFFF, 1, KIND_STRAIGHT, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 32'hC90F, 0));
        add_row(row(32'h80000000, 0, KIND_STRAIGHT, 32'h80000000,
                    32'h80000000, 32'hC90F, 0));
        add_row(row(32'h7FFFFFFF, 1, 2'd3, 0, 0, 32'h3243F, 0));
        add_row(row(32'h3243F, 1, KIND_LEFT, 32'h7FFF0000, 0, 32'hFFFCDBC1, 0));
        add_row(row(32'hFFFFFFFF, 1, KIND_RIGHT, 0, 0, 32'hFFFFFFFF, 0));
        add_row(row(32'h6487F, 1, KIND_LEFT, 0, 0, 32'h6487F, 0));

        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_seg_dist = '0;
        s_seg_length = '0;
        s_seg_kind = KIND_STRAIGHT;
        s_origin_x = '0;
        s_origin_y = '0;
        s_origin_heading = '0;
        radius = RADIUS_RESET;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) write_radius(radii[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (ph == 0) begin
                foreach (directed[i]) send_segment(directed[i]);
            end
            for (int n = 0; n < RAND_ITEMS; n++) send_segment(rand_segment());
            s_valid = 1'b0;
            while (pending_poses.size() > 0) @(negedge aclk);
            repeat (LATENCY + 4) @(negedge aclk);
        end

        $display("covered %0d segment words in, %0d poses out, over %0d radius settings",
                 words_in, words_out, NUM_PHASES);
        $display("with and without sender gaps and receiver stalls; %0d mismatches", errors);
        if (errors == 0 && pending_poses.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
